FILE: hw/rtl/vertex_transform_unit_macros.svh
// Assertion macros used by the checker file of the vertex transform unit.
`ifndef VERTEX_TRANSFORM_UNIT_MACROS_SVH
`define VERTEX_TRANSFORM_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VTU_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("vertex transform unit check failed");

// The consequent must hold in the cycle after the antecedent.
`define VTU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("vertex transform unit check failed");

`endif

FILE: hw/rtl/vtu_pkg.sv
package vtu_pkg;

    localparam int NUM_REGS  = 8;
    localparam int CFG_IDX_W = 3;
    localparam int OPND_W    = 33;
    localparam int PROD_W    = 65;
    localparam int ACC_W     = 68;
    localparam int TRANS_W   = 48;
    localparam int DIV_STEPS = 33;
    localparam int REM_W     = 65;

    typedef enum logic [2:0] {
        CMD_AFFINE     = 3'd0,
        CMD_INV_RIGID  = 3'd1,
        CMD_ROTATE     = 3'd2,
        CMD_ROT_TRANS  = 3'd3,
        CMD_PROJECTIVE = 3'd4
    } t_cmd;

    // Identity matrix, 1.0 on the diagonal.
    localparam logic [NUM_REGS-1:0][63:0] CFG_RESET = {
        64'h0001_0000_0000_0000, 64'h0, 64'h0000_0000_0001_0000, 64'h0,
        64'h0, 64'h0001_0000_0000_0000, 64'h0, 64'h0000_0000_0001_0000
    };

    typedef struct packed {
        logic [2:0]         command;
        logic signed [31:0] in_x;
        logic signed [31:0] in_y;
        logic signed [31:0] in_z;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic               divide_by_zero;
    } t_out_item;

    typedef logic [3:0][3:0][31:0] t_mat;

    typedef struct packed {
        logic [2:0]                  cmd;
        logic [3:0][ACC_W-1:0]       acc;
    } t_acc_item;

    typedef struct packed {
        logic                        proj;
        logic                        dz;
        logic [2:0]                  neg;
        logic [2:0]                  ovf;
        logic [2:0][31:0]            direct;
        logic [63:0]                 dvs;
        logic [2:0][REM_W-1:0]       rem;
        logic [2:0][DIV_STEPS-1:0]   nq;
    } t_div_item;

    // Round half up to Q16.16 and saturate to 32 bits.
    function automatic logic [31:0] round_sat(input logic [ACC_W-1:0] a);
        logic [ACC_W-1:0] b;
        logic             same;
        b    = a + ACC_W'(32768);
        same = (&b[ACC_W-1:47]) | ~(|b[ACC_W-1:47]);
        if (same) begin
            return b[47:16];
        end else if (b[ACC_W-1]) begin
            return 32'h8000_0000;
        end else begin
            return 32'h7FFF_FFFF;
        end
    endfunction

    // One restoring division step on each of the three lanes.
    function automatic t_div_item div_step(input t_div_item s);
        t_div_item        o;
        logic [REM_W-1:0] trial;
        logic             take;
        o = s;
        for (int l = 0; l < 3; l++) begin
            trial = {s.rem[l][63:0], s.nq[l][DIV_STEPS-1]};
            take  = trial >= {1'b0, s.dvs};
            o.rem[l] = take ? trial - {1'b0, s.dvs} : trial;
            o.nq[l]  = {s.nq[l][DIV_STEPS-2:0], take};
        end
        return o;
    endfunction

endpackage

FILE: hw/rtl/vtu_front.sv
module vtu_front import vtu_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  logic      i_vld,
    input  t_in_item  i_item,
    input  t_mat      i_mat,
    output logic      o_vld,
    output t_acc_item o_item
);

    t_cmd                      cmd;
    logic                      xp;
    logic signed [31:0]        vec [3];
    logic signed [OPND_W-1:0]  n1_opnd [3];
    logic [31:0]               n1_coef [4][3];
    logic [TRANS_W-1:0]        n1_trans [4];

    logic                      r1_vld, r2_vld, r3_vld, r4_vld;
    logic [2:0]                r1_cmd, r2_cmd, r3_cmd, r4_cmd;
    logic signed [OPND_W-1:0]  r1_opnd [3];
    logic [31:0]               r1_coef [4][3];
    logic [TRANS_W-1:0]        r1_trans [4];
    logic signed [PROD_W-1:0]  r2_prod [4][3];
    logic [TRANS_W-1:0]        r2_trans [4];
    logic signed [ACC_W-1:0]   r3_s0 [4];
    logic signed [ACC_W-1:0]   r3_s1 [4];
    logic [3:0][ACC_W-1:0]     r4_acc;

    // Operand selection: transposed commands swap the 3x3 indices, and
    // the inverse rigid command takes the translation off first.
    always_comb begin
        cmd    = t_cmd'(i_item.command);
        xp     = (cmd == CMD_INV_RIGID) || (cmd == CMD_ROT_TRANS);
        vec[0] = i_item.in_x;
        vec[1] = i_item.in_y;
        vec[2] = i_item.in_z;
        for (int c = 0; c < 3; c++) begin
            if (cmd == CMD_INV_RIGID) begin
                n1_opnd[c] = OPND_W'(vec[c]) - OPND_W'($signed(i_mat[c][3]));
            end else begin
                n1_opnd[c] = OPND_W'(vec[c]);
            end
            n1_coef[3][c] = i_mat[3][c];
        end
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                n1_coef[r][c] = xp ? i_mat[c][r] : i_mat[r][c];
            end
        end
        for (int r = 0; r < 4; r++) begin
            if ((cmd == CMD_AFFINE) || (cmd == CMD_PROJECTIVE)) begin
                n1_trans[r] = {i_mat[r][3], 16'h0000};
            end else begin
                n1_trans[r] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_cmd <= i_item.command;
            r2_cmd <= r1_cmd;
            r3_cmd <= r2_cmd;
            r4_cmd <= r3_cmd;
            r1_opnd  <= n1_opnd;
            r1_coef  <= n1_coef;
            r1_trans <= n1_trans;
            r2_trans <= r1_trans;
            for (int r = 0; r < 4; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r2_prod[r][c] <= $signed({{OPND_W{r1_coef[r][c][31]}}, r1_coef[r][c]})
                                   * $signed({{32{r1_opnd[c][OPND_W-1]}}, r1_opnd[c]});
                end
                r3_s0[r] <= ACC_W'(r2_prod[r][0]) + ACC_W'(r2_prod[r][1]);
                r3_s1[r] <= ACC_W'(r2_prod[r][2]) + ACC_W'($signed(r2_trans[r]));
                r4_acc[r] <= r3_s0[r] + r3_s1[r];
            end
        end
    end

    assign o_vld       = r4_vld;
    assign o_item.cmd  = r4_cmd;
    assign o_item.acc  = r4_acc;

endmodule

FILE: hw/rtl/vtu_norm.sv
module vtu_norm import vtu_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  logic      i_vld,
    input  t_acc_item i_item,
    output logic      o_vld,
    output t_div_item o_item
);

    logic              r5_vld, r6_vld;
    logic              r5_proj;
    logic [2:0][31:0]  r5_direct;
    logic [2:0]        r5_nneg;
    logic [63:0]       r5_nmag [3];
    logic              r5_dneg;
    logic [63:0]       r5_dmag;
    t_div_item         r6_item;
    logic [ACC_W-1:0]  abs_v [4];
    t_div_item         n6_item;

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            abs_v[r] = i_item.acc[r][ACC_W-1] ? -i_item.acc[r] : i_item.acc[r];
        end
    end

    // Projective items are set up for the divider: the dividend is the
    // numerator magnitude shifted by 16, the first 47 bits preloaded.
    always_comb begin
        n6_item.proj   = r5_proj;
        n6_item.dz     = (r5_dmag == 64'd0);
        n6_item.direct = r5_direct;
        n6_item.dvs    = r5_dmag;
        for (int l = 0; l < 3; l++) begin
            n6_item.neg[l] = r5_nneg[l] ^ r5_dneg;
            n6_item.ovf[l] = {17'd0, r5_nmag[l][63:17]} >= r5_dmag;
            n6_item.rem[l] = {18'd0, r5_nmag[l][63:17]};
            n6_item.nq[l]  = {r5_nmag[l][16:0], 16'h0000};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
            r6_vld <= 1'b0;
        end else if (i_en) begin
            r5_vld <= i_vld;
            r6_vld <= r5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_proj <= (t_cmd'(i_item.cmd) == CMD_PROJECTIVE);
            for (int l = 0; l < 3; l++) begin
                r5_direct[l] <= (i_item.cmd <= CMD_ROT_TRANS) ?
                                round_sat(i_item.acc[l]) : 32'd0;
                r5_nneg[l]   <= i_item.acc[l][ACC_W-1];
                r5_nmag[l]   <= abs_v[l][63:0];
            end
            r5_dneg <= i_item.acc[3][ACC_W-1];
            r5_dmag <= abs_v[3][63:0];
            r6_item <= n6_item;
        end
    end

    assign o_vld  = r6_vld;
    assign o_item = r6_item;

endmodule

FILE: hw/rtl/vtu_divider.sv
module vtu_divider import vtu_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  logic      i_vld,
    input  t_div_item i_item,
    output logic      o_vld,
    output t_div_item o_item
);

    logic      r_vld [DIV_STEPS];
    t_div_item r_stg [DIV_STEPS];

    // One quotient bit per stage on all three lanes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '{default: 1'b0};
        end else if (i_en) begin
            r_vld[0] <= i_vld;
            for (int k = 1; k < DIV_STEPS; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stg[0] <= div_step(i_item);
            for (int k = 1; k < DIV_STEPS; k++) begin
                r_stg[k] <= div_step(r_stg[k-1]);
            end
        end
    end

    assign o_vld  = r_vld[DIV_STEPS-1];
    assign o_item = r_stg[DIV_STEPS-1];

endmodule

FILE: hw/rtl/vtu_out.sv
module vtu_out import vtu_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_vld,
    input  t_div_item i_item,
    input  logic      i_stall,
    output logic      o_en,
    output logic      o_vld,
    output t_out_item o_item
);

    logic              r_out_vld, r_skid_vld;
    t_out_item         r_out, r_skid;
    t_out_item         res;
    logic [2:0][31:0]  lane;
    logic [33:0]       qr;
    logic [31:0]       lim, mag;
    logic              rnd;

    // Final rounding of the quotient, ties away from zero, then saturation.
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            rnd = {i_item.rem[l][63:0], 1'b0} >= {1'b0, i_item.dvs};
            qr  = {1'b0, i_item.nq[l]} + 34'(rnd);
            lim = i_item.neg[l] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            mag = (i_item.ovf[l] || (qr > {2'b00, lim})) ? lim : qr[31:0];
            if (!i_item.proj) begin
                lane[l] = i_item.direct[l];
            end else if (i_item.dz) begin
                lane[l] = 32'd0;
            end else begin
                lane[l] = i_item.neg[l] ? -mag : mag;
            end
        end
        res.out_x          = lane[0];
        res.out_y          = lane[1];
        res.out_z          = lane[2];
        res.divide_by_zero = i_item.proj & i_item.dz;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (!i_stall) begin
                r_skid_vld <= 1'b0;
            end
        end else if (i_vld) begin
            if (r_out_vld && i_stall) begin
                r_skid_vld <= 1'b1;
            end else begin
                r_out_vld <= 1'b1;
            end
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (!i_stall) begin
                r_out <= r_skid;
            end
        end else if (i_vld) begin
            if (r_out_vld && i_stall) begin
                r_skid <= res;
            end else begin
                r_out <= res;
            end
        end
    end

    assign o_en   = !r_skid_vld;
    assign o_vld  = r_out_vld;
    assign o_item = r_out;

endmodule

FILE: hw/rtl/vertex_transform_unit.sv
// Vertex transform unit. Each input transaction carries a command and a
// signed Q16.16 vector (x, y, z) and yields exactly one output transaction
// with the transformed vector, saturated to 32 bits, and a divide-by-zero
// flag. The 4x4 matrix lives in eight 64-bit configuration registers, two
// Q16.16 entries each (even column in the low half); it resets to the
// identity and may only be rewritten while no transaction is in flight.
// Commands: affine, inverse rigid, rotate, rotate by the transpose and
// projective; unused command codes give a zero vector. The unit takes one
// vertex per clock cycle for any command mix while the input stall is low
// and delivers results in order through multiply and accumulate, rounding
// and divider setup, the projective divider (one quotient bit per stage)
// and the output register. A two-entry output buffer lets the unit keep
// accepting vertices while a result waits; the input stall rises only once
// that buffer is full.
module vertex_transform_unit import vtu_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_item,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]          i_cfg_data
);

    logic [NUM_REGS-1:0][63:0] r_cfg;
    t_mat                      mat;
    logic                      en;
    logic                      front_vld, norm_vld, div_vld;
    t_acc_item                 front_item;
    t_div_item                 norm_item, div_item;

    // Configuration writes are always accepted.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_cfg[i_cfg_index] <= i_cfg_data;
        end
    end

    // Unpack the registers into a row by column matrix of Q16.16 entries.
    always_comb begin
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                mat[r][c] = r_cfg[CFG_IDX_W'(r * 2 + c / 2)][(c % 2) * 32 +: 32];
            end
        end
    end

    // The whole pipeline advances together; it holds only while the
    // output buffer is full, so a stall never drops or repeats an item.
    assign o_in_stall = !en;

    vtu_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (i_in_valid),
        .i_item  (i_in_item),
        .i_mat   (mat),
        .o_vld   (front_vld),
        .o_item  (front_item)
    );

    vtu_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (front_vld),
        .i_item  (front_item),
        .o_vld   (norm_vld),
        .o_item  (norm_item)
    );

    vtu_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (norm_vld),
        .i_item  (norm_item),
        .o_vld   (div_vld),
        .o_item  (div_item)
    );

    vtu_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (div_vld),
        .i_item  (div_item),
        .i_stall (i_out_stall),
        .o_en    (en),
        .o_vld   (o_out_valid),
        .o_item  (o_out_item)
    );

endmodule

FILE: hw/rtl/vtu_checker.sv
`include "vertex_transform_unit_macros.svh"

module vtu_checker import vtu_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    logic held;
    logic shown_dz;
    logic zero_vec;

    assign held     = o_out_valid && i_out_stall;
    assign shown_dz = o_out_valid && o_out_item.divide_by_zero;
    assign zero_vec = (o_out_item.out_x == 32'd0) && (o_out_item.out_y == 32'd0) &&
                      (o_out_item.out_z == 32'd0);

    `VTU_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, held, o_out_valid && $stable(o_out_item))
    `VTU_ASSERT_SAME(a_dz_zero, i_clk, i_rst_n, shown_dz, zero_vec)
    `VTU_ASSERT_SAME(a_stall_cause, i_clk, i_rst_n, $rose(o_in_stall), $past(held))
    `VTU_ASSERT_SAME(a_stall_full, i_clk, i_rst_n, o_in_stall, o_out_valid)

endmodule

bind vertex_transform_unit vtu_checker u_vtu_checker (.*);
